// File: sv/dasd_pkg.sv
// Shared types, constants and calendar functions for the date add/subtract block.
package dasd_pkg;

    localparam int MAX_YEAR    = 9999;
    localparam int YEAR_CYCLE  = 400;   // Gregorian leap pattern repeats every 400 years
    localparam int CENTURY     = 100;
    localparam int MONTHS      = 12;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int OFF_W   = 16;
    localparam int STAT_W  = 2;
    localparam int T_W     = OFF_W + 2; // signed running day count

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic    load;      // capture a new request
        logic    reduce;    // year residue minus one cycle of 400
        logic    step;      // one month of the walk
        logic    load_out;  // move the result into the output register
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic rem_ge;       // year residue not yet below 400
        logic invalid;      // input date fails the validity check
        logic range_bad;    // input year outside 1..MAX_YEAR
        logic done;         // walk has settled
        logic oob;          // next month step would leave the year range
    } t_stat;

    // Leap test on the year modulo 400.
    function automatic logic f_leap(input logic [YEAR_W-1:0] rem);
        logic century;
        century = (rem == YEAR_W'(CENTURY)) || (rem == YEAR_W'(2 * CENTURY))
               || (rem == YEAR_W'(3 * CENTURY));
        return (rem[1:0] == 2'b00) && !century;
    endfunction

    // Month length; zero for a month code outside 1..12.
    function automatic logic [DAY_W-1:0] f_days(input logic [MONTH_W-1:0] m, input logic leap);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

// File: sv/dasd_in_if.sv
// Request channel: start date, offset and direction.
interface dasd_in_if
    import dasd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [DAY_W-1:0]   day_in;
    logic [MONTH_W-1:0] month_in;
    logic [YEAR_W-1:0]  year_in;
    logic [OFF_W-1:0]   offset_days;

    modport source (output valid, req_type, day_in, month_in, year_in, offset_days,
                    input ready);
    modport sink   (input valid, req_type, day_in, month_in, year_in, offset_days,
                    output ready);
endinterface

// File: sv/dasd_out_if.sv
// Result channel: resulting date and status.
interface dasd_out_if
    import dasd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   day_out;
    logic [MONTH_W-1:0] month_out;
    logic [YEAR_W-1:0]  year_out;
    logic [STAT_W-1:0]  status;

    modport source (output valid, day_out, month_out, year_out, status, input ready);
    modport sink   (input valid, day_out, month_out, year_out, status, output ready);
endinterface

// File: sv/date_add_subtract_days.sv
// Gregorian date add/subtract: moves a date forward or back by up to 65535 days. One request is
// worked at a time. After the request transfer the year is reduced modulo 400 by repeated
// subtraction of 400, the date is then checked, and the walk advances one month per cycle. The
// result sits in an output register, so a new request transfer is taken while it waits. Status 1
// flags an invalid input date, status 2 a year leaving 1..9999; both echo the input date.
module date_add_subtract_days
    import dasd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dasd_in_if.sink   i_req,
    dasd_out_if.source o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    dasd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dasd_dp u_dp (
        .i_clk      (i_clk),
        .i_req_type (i_req.req_type),
        .i_day      (i_req.day_in),
        .i_month    (i_req.month_in),
        .i_year     (i_req.year_in),
        .i_offset   (i_req.offset_days),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_day      (o_rsp.day_out),
        .o_month    (o_rsp.month_out),
        .o_year     (o_rsp.year_out),
        .o_status   (o_rsp.status)
    );

`ifndef SYNTHESIS
    // a request transfer always starts work, so the input side closes next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request side still open after transfer");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.status == ST_OK) || (o_rsp.status == ST_INVALID)
                        || (o_rsp.status == ST_RANGE))
        else $error("undefined status code on result");

    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status == ST_OK |->
            o_rsp.day_out != '0 && o_rsp.month_out != '0
            && o_rsp.month_out <= MONTH_W'(MONTHS) && o_rsp.year_out != '0
            && o_rsp.year_out <= YEAR_W'(MAX_YEAR))
        else $error("result date out of calendar range");
`endif

endmodule

// File: sv/dasd_dp.sv
// Datapath: request registers, year residue, month walk and output register.
module dasd_dp
    import dasd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_req_type,
    input  logic [DAY_W-1:0]   i_day,
    input  logic [MONTH_W-1:0] i_month,
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [OFF_W-1:0]   i_offset,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic [DAY_W-1:0]   o_day,
    output logic [MONTH_W-1:0] o_month,
    output logic [YEAR_W-1:0]  o_year,
    output logic [STAT_W-1:0]  o_status
);

    logic                  r_sub;
    logic [DAY_W-1:0]      r_d0;
    logic [MONTH_W-1:0]    r_m0;
    logic [YEAR_W-1:0]     r_y0;
    logic signed [T_W-1:0] r_t;
    logic [MONTH_W-1:0]    r_m;
    logic [YEAR_W-1:0]     r_y;
    logic [YEAR_W-1:0]     r_rem;
    logic [DAY_W-1:0]      r_o_day;
    logic [MONTH_W-1:0]    r_o_month;
    logic [YEAR_W-1:0]     r_o_year;
    logic [STAT_W-1:0]     r_o_status;

    logic signed [T_W-1:0] n_t;
    logic [MONTH_W-1:0]    n_m;
    logic [YEAR_W-1:0]     n_y;
    logic [YEAR_W-1:0]     n_rem;

    logic [T_W-1:0]        start_add;
    logic [T_W-1:0]        start_sub;
    logic [DAY_W-1:0]      dim_cur;
    logic [DAY_W-1:0]      dim_prev;
    logic [DAY_W-1:0]      dim_in;
    logic [MONTH_W-1:0]    m_prev;
    logic [YEAR_W-1:0]     y_prev;
    logic [YEAR_W-1:0]     rem_prev;
    logic                  wrap_back;
    logic                  done_add;
    logic                  done_sub;

    assign start_add = T_W'(i_day) + T_W'(i_offset);
    assign start_sub = T_W'(i_day) - T_W'(i_offset);

    assign dim_cur   = f_days(r_m, f_leap(r_rem));
    assign wrap_back = (r_m == 4'd1);
    assign m_prev    = wrap_back ? MONTH_W'(MONTHS) : r_m - 4'd1;
    assign y_prev    = wrap_back ? r_y - 14'd1 : r_y;
    assign rem_prev  = !wrap_back ? r_rem
                     : (r_rem == '0) ? YEAR_W'(YEAR_CYCLE - 1) : r_rem - 14'd1;
    assign dim_prev  = f_days(m_prev, f_leap(rem_prev));
    assign dim_in    = f_days(r_m0, f_leap(r_rem));

    assign done_add  = r_t <= $signed(T_W'(dim_cur));
    assign done_sub  = r_t > 0;

    always_comb begin
        o_stat.rem_ge    = r_rem >= YEAR_W'(YEAR_CYCLE);
        o_stat.invalid   = (r_m0 == '0) || (r_m0 > MONTH_W'(MONTHS)) || (r_d0 == '0)
                         || (r_d0 > dim_in);
        o_stat.range_bad = (r_y0 == '0) || (r_y0 > YEAR_W'(MAX_YEAR));
        o_stat.done      = r_sub ? done_sub : done_add;
        o_stat.oob       = r_sub ? (!done_sub && wrap_back && r_y == 14'd1)
                                 : (!done_add && r_m == MONTH_W'(MONTHS)
                                    && r_y == YEAR_W'(MAX_YEAR));
    end

    always_comb begin
        n_t   = r_t;
        n_m   = r_m;
        n_y   = r_y;
        n_rem = r_rem;
        if (r_sub) begin
            n_t   = r_t + $signed(T_W'(dim_prev));
            n_m   = m_prev;
            n_y   = y_prev;
            n_rem = rem_prev;
        end else begin
            n_t = r_t - $signed(T_W'(dim_cur));
            if (r_m == MONTH_W'(MONTHS)) begin
                n_m   = 4'd1;
                n_y   = r_y + 14'd1;
                n_rem = (r_rem == YEAR_W'(YEAR_CYCLE - 1)) ? '0 : r_rem + 14'd1;
            end else begin
                n_m = r_m + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sub <= i_req_type;
            r_d0  <= i_day;
            r_m0  <= i_month;
            r_y0  <= i_year;
            r_t   <= i_req_type ? $signed(start_sub) : $signed(start_add);
            r_m   <= i_month;
            r_y   <= i_year;
            r_rem <= i_year;
        end else if (i_cmd.reduce) begin
            r_rem <= r_rem - YEAR_W'(YEAR_CYCLE);
        end else if (i_cmd.step) begin
            r_t   <= n_t;
            r_m   <= n_m;
            r_y   <= n_y;
            r_rem <= n_rem;
        end
        if (i_cmd.load_out) begin
            r_o_status <= i_cmd.status;
            if (i_cmd.status == ST_OK) begin
                r_o_day   <= r_t[DAY_W-1:0];
                r_o_month <= r_m;
                r_o_year  <= r_y;
            end else begin
                r_o_day   <= r_d0;
                r_o_month <= r_m0;
                r_o_year  <= r_y0;
            end
        end
    end

    assign o_day    = r_o_day;
    assign o_month  = r_o_month;
    assign o_year   = r_o_year;
    assign o_status = r_o_status;

endmodule

// File: sv/dasd_ctrl.sv
// Controller: sequences year reduction, date check, month walk and result hand-off.
module dasd_ctrl
    import dasd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_WALK,
        S_EMIT
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_out_valid, n_out_valid;
    logic    out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_stat.rem_ge) begin
                    o_cmd.reduce = 1'b1;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.invalid) begin
                    n_status = ST_INVALID;
                    n_state  = S_EMIT;
                end else if (i_stat.range_bad) begin
                    n_status = ST_RANGE;
                    n_state  = S_EMIT;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.done) begin
                    n_state = S_EMIT;
                end else if (i_stat.oob) begin
                    n_status = ST_RANGE;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: verif/testbench.sv
// Testbench for the date add/subtract block: calendar predictor, scoreboard and handshake drivers.
`timescale 1ns / 1ps

module testbench;
    import dasd_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int RANDOM_ITEMS = 250;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic               sub;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [OFF_W-1:0]   offset;
    } t_date_req;

    typedef struct {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        t_status            status;
    } t_date_rsp;

    class date_scoreboard;
        t_date_rsp   expected_dates[$];
        int unsigned fail_count;

        function new();
            fail_count = 0;
        endfunction

        static function int days_of(int m, int y);
            bit leap;
            leap = (y % 4 == 0) && ((y % CENTURY != 0) || (y % YEAR_CYCLE == 0));
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        // Walks month by month; error cases echo the request date.
        static function t_date_rsp shift_date(t_date_req r);
            t_date_rsp res;
            int        t;
            int        m;
            int        y;
            res.day    = r.day;
            res.month  = r.month;
            res.year   = r.year;
            res.status = ST_OK;
            m = r.month;
            y = r.year;
            if (m < 1 || m > MONTHS || r.day == 0 || int'(r.day) > days_of(m, y)) begin
                res.status = ST_INVALID;
                return res;
            end
            if (y < 1 || y > MAX_YEAR) begin
                res.status = ST_RANGE;
                return res;
            end
            if (!r.sub) begin
                t = int'(r.day) + int'(r.offset);
                while (t > days_of(m, y)) begin
                    t -= days_of(m, y);
                    m++;
                    if (m > MONTHS) begin
                        m = 1;
                        y++;
                        if (y > MAX_YEAR) begin
                            res.status = ST_RANGE;
                            return res;
                        end
                    end
                end
            end else begin
                t = int'(r.day) - int'(r.offset);
                while (t <= 0) begin
                    m--;
                    if (m == 0) begin
                        m = MONTHS;
                        y--;
                        if (y < 1) begin
                            res.status = ST_RANGE;
                            return res;
                        end
                    end
                    t += days_of(m, y);
                end
            end
            res.day   = t[DAY_W-1:0];
            res.month = m[MONTH_W-1:0];
            res.year  = y[YEAR_W-1:0];
            return res;
        endfunction

        function void note_request(t_date_req r);
            expected_dates.push_back(shift_date(r));
        endfunction

        function void check_result(t_date_rsp got);
            t_date_rsp exp_rsp;
            if (expected_dates.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result %0d/%0d/%0d status %0d", $realtime,
                             got.day, got.month, got.year, got.status);
                return;
            end
            exp_rsp = expected_dates.pop_front();
            if (got.day !== exp_rsp.day || got.month !== exp_rsp.month
                    || got.year !== exp_rsp.year || got.status !== exp_rsp.status) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: mismatch expected %0d/%0d/%0d status %0d, got %0d/%0d/%0d status %0d",
                             $realtime, exp_rsp.day, exp_rsp.month, exp_rsp.year, exp_rsp.status,
                             got.day, got.month, got.year, got.status);
            end
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dasd_in_if  req_if ();
    dasd_out_if rsp_if ();

    date_add_subtract_days u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    date_scoreboard sb;
    int unsigned    cycle_count = 0;
    int             burst_left  = 0;
    int             stall_left  = 0;
    int             stall_mode  = 0;
    int unsigned    pat_idx     = 0;
    logic [31:0]    stall_pattern = '1;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: free-running, patterned or heavily stalled, the mode re-picked at random after each span
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode    = $urandom_range(0, 2);
            stall_left    = $urandom_range(50, 400);
            stall_pattern = $urandom;
        end
        stall_left--;
        pat_idx++;
        case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= stall_pattern[pat_idx % 32];
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result('{rsp_if.day_out, rsp_if.month_out, rsp_if.year_out,
                              t_status'(rsp_if.status)});
    end

    function automatic t_date_req date_req(int sub, int d, int m, int y, int off);
        t_date_req r;
        r.sub    = sub[0];
        r.day    = d[DAY_W-1:0];
        r.month  = m[MONTH_W-1:0];
        r.year   = y[YEAR_W-1:0];
        r.offset = off[OFF_W-1:0];
        return r;
    endfunction

    // Mostly well-formed dates with random offsets; the rest is raw noise on every field
    function automatic t_date_req random_request();
        int pick;
        int m;
        int y;
        int off;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return date_req($urandom_range(0, 1), $urandom_range(0, 31), $urandom_range(0, 15),
                            $urandom_range(0, 16383), $urandom_range(0, 400));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            y = $urandom_range(1, MAX_YEAR);
        else if (pick < 85)
            y = $urandom_range(1, 150);
        else
            y = $urandom_range(MAX_YEAR - 150, MAX_YEAR);
        m    = $urandom_range(1, MONTHS);
        pick = $urandom_range(0, 99);
        if (pick < 55)
            off = $urandom_range(0, 400);
        else if (pick < 80)
            off = $urandom_range(0, 5000);
        else if (pick < 92)
            off = $urandom_range(0, 65535);
        else
            off = $urandom_range(30000, 65535);
        return date_req($urandom_range(0, 1), $urandom_range(1, date_scoreboard::days_of(m, y)),
                        m, y, off);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic push_request(t_date_req r);
        req_if.valid       <= 1'b1;
        req_if.req_type    <= r.sub;
        req_if.day_in      <= r.day;
        req_if.month_in    <= r.month;
        req_if.year_in     <= r.year;
        req_if.offset_days <= r.offset;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic send_item(t_date_req r);
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        push_request(r);
    endtask

    initial begin
        sb                 = new();
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = 1'b0;
        req_if.day_in      = '0;
        req_if.month_in    = '0;
        req_if.year_in     = '0;
        req_if.offset_days = '0;
        rsp_if.ready       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(date_req(0, 15, 6, 2023, 0));
        send_item(date_req(0, 1, 1, 1, 65535));
        send_item(date_req(1, 31, 12, MAX_YEAR, 65535));
        send_item(date_req(1, 1, 1, 1, 1));           // walks below year 1
        send_item(date_req(0, 31, 12, MAX_YEAR, 1));  // walks past the top year
        send_item(date_req(0, 1, 0, 2000, 5));
        send_item(date_req(0, 1, 13, 2000, 5));
        send_item(date_req(1, 31, 15, 16383, 65535)); // validity check wins over range
        send_item(date_req(0, 0, 5, 2000, 7));
        send_item(date_req(0, 31, 4, 2001, 1));
        send_item(date_req(0, 29, 2, 1900, 1));       // century, not leap
        send_item(date_req(0, 29, 2, 2000, 365));
        send_item(date_req(1, 29, 2, 2024, 1));
        send_item(date_req(0, 10, 10, 0, 3));
        send_item(date_req(0, 10, 10, 16383, 3));
        send_item(date_req(1, 31, 12, 10000, 0));
        send_item(date_req(1, 1, 3, 2023, 1));        // lands on a month end
        send_item(date_req(1, 1, 3, 2024, 1));
        send_item(date_req(1, 1, 1, 2000, 1));
        send_item(date_req(0, 28, 2, 1900, 1));
        send_item(date_req(1, 15, 8, 2000, 65535));
        send_item(date_req(1, 0, 0, 0, 0));
        send_item(date_req(0, 31, 1, 2023, 31));

        repeat (RANDOM_ITEMS) send_item(random_request());
        req_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
sv/dasd_pkg.sv
sv/dasd_in_if.sv
sv/dasd_out_if.sv
sv/dasd_dp.sv
sv/dasd_ctrl.sv
sv/date_add_subtract_days.sv
verif/testbench.sv
